@@ hdl/ssbt_pkg.sv @@
// Package for the splice site bucket table: request codes, status codes, config
// indices, reset values, sequencer states and default sizes. No dependencies.
package ssbt_pkg;

    localparam int BLOCK_SHIFT_DEF = 15;
    localparam int NUM_BLOCKS_DEF  = 131072;
    localparam int MAX_ENTRIES_DEF = 65536;

    localparam logic [31:0] LAST_POS_RESET = 32'hFFFF_FFFF;
    localparam logic [7:0]  WINDOW_RESET   = 8'd5;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_POS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 1'd1;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_WINDOW = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISS     = 2'd1,
        ST_FULL     = 2'd2,
        ST_RESERVED = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,     // sweeping the block head memory after reset
        S_IDLE,
        S_HEAD_RD,   // issue head read
        S_HEAD_WT,   // head data returns
        S_ENT_WT,    // entry data returns
        S_INSERT,    // write new entry, fix head link
        S_HIT_INC,   // update hit count
        S_NEXT_END,  // write predecessor link, move on to right end of pair
        S_LOAD_FND,  // read found entry fields
        S_FND_WT,
        S_OUT
    } state_t;

endpackage

@@ hdl/splice_site_bucket_table.sv @@
// Splice site bucket table: block heads and entry pool in internal memories,
// walked one entry per read by a single sequencer. Depends on ssbt_pkg.
//
// channel | dir | tdata fields (low bit first)
// s_      | in  | req_type[1:0], position_a[33:2], position_b[65:34] (72 bits)
// m_      | out | site_id[15:0], matched_position[47:16], opposite_position[79:48],
//         |     | status[81:80] (88 bits)
// cfg     | in  | cfg_we, cfg_index (0 last_genome_pos, 1 search_window), cfg_data
//
// Lookup and window search: the head read, a walk over the list entries up to
// the list end or a stop, a fetch of a match, then the result; a window search
// may walk a second list. Add walks once per end (once if both are equal), each
// end taking the head read, the walk, an update and a move on to the next end.
// After reset the head memory is swept one entry a cycle, with no request
// taken meanwhile. s_tready is low from acceptance until the result is taken on
// the master side.
module splice_site_bucket_table #(
    parameter int BLOCK_SHIFT = ssbt_pkg::BLOCK_SHIFT_DEF,
    parameter int NUM_BLOCKS  = ssbt_pkg::NUM_BLOCKS_DEF,
    parameter int MAX_ENTRIES = ssbt_pkg::MAX_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // req_type, position_a, position_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // site_id, matched_position, opposite_position, status
    input  logic                           cfg_we,
    input  logic [ssbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);
    import ssbt_pkg::*;

    localparam int BW = $clog2(NUM_BLOCKS);
    localparam int EW = $clog2(MAX_ENTRIES);
    localparam logic [EW:0] POOL_LIMIT = (EW+1)'(MAX_ENTRIES - 1);

    // memories
    logic [EW-1:0] head_mem [NUM_BLOCKS];
    logic [31:0]   pos_mem  [MAX_ENTRIES];
    logic [31:0]   opp_mem  [MAX_ENTRIES];
    logic [EW-1:0] next_mem [MAX_ENTRIES];
    logic [31:0]   hits_mem [MAX_ENTRIES];

    state_t state_reg, state_next;

    logic [31:0] last_pos_reg;
    logic [7:0]  window_reg;
    logic [BW:0] clr_reg;

    req_t        req_reg;
    logic [31:0] pa_reg, pb_reg;
    logic        second_reg;       // working on right end
    logic [31:0] key_reg, other_reg;
    logic [31:0] low_reg, high_reg;
    logic [BW-1:0] blk_reg, blk_hi_reg;
    logic [EW-1:0] prev_reg, cur_reg;
    logic [EW:0]   used_reg;
    logic [EW-1:0] newid_reg;
    logic          full_reg;
    logic          link_reg;       // predecessor link still to be written

    logic [EW-1:0] head_q;
    logic [31:0]   pos_q, opp_q, hits_q;
    logic [EW-1:0] next_q;

    logic [15:0] o_id_reg;
    logic [31:0] o_mpos_reg, o_opp_reg;
    status_t     o_st_reg;

    // memory controls
    logic          head_we;
    logic [BW-1:0] head_wa, head_ra;
    logic [EW-1:0] head_wd;
    logic          ent_we, next_we, hits_we;
    logic [EW-1:0] ent_wa, next_wa, ent_ra;
    logic [EW-1:0] next_wd;
    logic [31:0]   hits_wd;

    function automatic logic [BW-1:0] blk_of(input logic [31:0] p);
        logic [31:0] s;
        s = p >> BLOCK_SHIFT;
        return s[BW-1:0];
    endfunction

    logic [31:0] s_pa, s_pb;
    assign s_pa = s_tdata[33:2];
    assign s_pb = s_tdata[65:34];

    // window bounds from query
    logic [32:0] hi_sum;
    logic [31:0] lo_c, hi_c;
    always_comb begin
        hi_sum = {1'b0, s_pa} + {25'd0, window_reg};
        lo_c   = (s_pa < {24'd0, window_reg}) ? 32'd0 : s_pa - {24'd0, window_reg};
        if (lo_c >= last_pos_reg) lo_c = 32'd0;
        hi_c = (hi_sum >= {1'b0, last_pos_reg}) ? last_pos_reg : hi_sum[31:0];
    end

    logic s_acc;
    assign s_acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {6'd0, o_st_reg, o_opp_reg, o_mpos_reg, o_id_reg};

    // walk decisions
    logic cur_nz, pos_lt, pos_eq;
    assign cur_nz = (cur_reg != '0);
    assign pos_lt = pos_q < key_reg;
    assign pos_eq = pos_q == key_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (clr_reg == (BW+1)'(NUM_BLOCKS - 1)) state_next = S_IDLE;
            S_IDLE:     if (s_acc) begin
                if (s_tdata[1:0] == REQ_NONE) state_next = S_OUT;
                else state_next = S_HEAD_RD;
            end
            S_HEAD_RD:  state_next = S_HEAD_WT;
            S_HEAD_WT:  state_next = S_ENT_WT;
            S_ENT_WT: begin
                if (!cur_nz) begin
                    if (req_reg == REQ_ADD) state_next = S_INSERT;
                    else if (req_reg == REQ_WINDOW && blk_reg != blk_hi_reg)
                        state_next = S_HEAD_RD;
                    else state_next = S_OUT;
                end else if (req_reg == REQ_ADD) begin
                    if (pos_lt) state_next = S_ENT_WT;
                    else if (pos_eq) state_next = S_HIT_INC;
                    else state_next = S_INSERT;
                end else if (req_reg == REQ_LOOKUP) begin
                    state_next = pos_eq ? S_LOAD_FND : S_ENT_WT;
                end else begin
                    if (pos_q > high_reg) state_next = S_OUT;
                    else if (pos_q < low_reg) state_next = S_ENT_WT;
                    else state_next = S_LOAD_FND;
                end
            end
            S_INSERT, S_HIT_INC: state_next = S_NEXT_END;
            S_NEXT_END: state_next = (!second_reg && pa_reg != pb_reg) ? S_HEAD_RD : S_OUT;
            S_LOAD_FND: state_next = S_FND_WT;
            S_FND_WT:   state_next = S_OUT;
            S_OUT:      if (m_tready) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    logic pool_ok;
    assign pool_ok = used_reg < POOL_LIMIT;

    // memory controls
    always_comb begin
        head_we = 1'b0; head_wa = blk_reg; head_wd = '0;
        ent_we = 1'b0; ent_wa = used_reg[EW-1:0] + EW'(1);
        next_we = 1'b0; next_wa = prev_reg; next_wd = '0;
        hits_we = 1'b0; hits_wd = 32'd1;
        head_ra = blk_reg;
        ent_ra  = (state_reg == S_HEAD_WT) ? head_q : next_q;
        unique case (state_reg)
            S_CLEAR: begin
                head_we = 1'b1; head_wa = clr_reg[BW-1:0];
            end
            // keep the current entry on the read port when the walk stops
            S_ENT_WT: ent_ra = (state_next == S_ENT_WT) ? next_q : cur_reg;
            S_INSERT: if (pool_ok) begin
                ent_we = 1'b1; hits_we = 1'b1;
                if (prev_reg == '0) begin
                    head_we = 1'b1; head_wd = ent_wa;
                end
            end
            S_HIT_INC: begin
                hits_we = 1'b1; ent_wa = cur_reg;
                hits_wd = (hits_q == 32'hFFFF_FFFF) ? hits_q : hits_q + 32'd1;
            end
            S_NEXT_END: if (link_reg) begin
                next_we = 1'b1; next_wd = newid_reg;
            end
            S_LOAD_FND: ent_ra = cur_reg;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (head_we) head_mem[head_wa] <= head_wd;
        head_q <= head_mem[head_ra];
        if (ent_we) begin
            pos_mem[ent_wa] <= key_reg;
            opp_mem[ent_wa] <= other_reg;
        end
        if (ent_we) next_mem[ent_wa] <= cur_reg;
        else if (next_we) next_mem[next_wa] <= next_wd;
        if (hits_we) hits_mem[ent_wa] <= hits_wd;
        pos_q  <= pos_mem[ent_ra];
        opp_q  <= opp_mem[ent_ra];
        next_q <= next_mem[ent_ra];
        hits_q <= hits_mem[ent_ra];
    end

    // control and datapath registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            used_reg     <= '0;
            last_pos_reg <= LAST_POS_RESET;
            window_reg   <= WINDOW_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) clr_reg <= clr_reg + 1'b1;
            if (cfg_we) begin
                if (cfg_index == CFG_LAST_POS) last_pos_reg <= cfg_data;
                if (cfg_index == CFG_WINDOW)   window_reg   <= cfg_data[7:0];
            end
            if (state_reg == S_INSERT && pool_ok) used_reg <= used_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: if (s_acc) begin
                req_reg    <= req_t'(s_tdata[1:0]);
                pa_reg     <= s_pa;
                pb_reg     <= s_pb;
                second_reg <= 1'b0;
                key_reg    <= s_pa;
                other_reg  <= s_pb;
                low_reg    <= lo_c;
                high_reg   <= hi_c;
                blk_reg    <= (s_tdata[1:0] == REQ_WINDOW) ? blk_of(lo_c) : blk_of(s_pa);
                blk_hi_reg <= blk_of(hi_c);
                newid_reg  <= '0;
                full_reg   <= 1'b0;
                link_reg   <= 1'b0;
                o_id_reg   <= '0;
                o_mpos_reg <= '0;
                o_opp_reg  <= '0;
                o_st_reg   <= ST_MISS;
            end
            S_HEAD_WT: begin
                prev_reg <= '0;
                cur_reg  <= head_q;
            end
            S_ENT_WT: begin
                if (!cur_nz) begin
                    if (req_reg == REQ_WINDOW) blk_reg <= blk_hi_reg;
                end else if (state_next == S_ENT_WT) begin
                    prev_reg <= cur_reg;
                    cur_reg  <= next_q;
                end
            end
            S_INSERT: begin
                if (pool_ok) newid_reg <= ent_wa;
                else full_reg <= 1'b1;
                link_reg <= pool_ok && (prev_reg != '0);
            end
            S_NEXT_END: begin
                second_reg <= 1'b1;
                key_reg    <= pb_reg;
                other_reg  <= pa_reg;
                blk_reg    <= blk_of(pb_reg);
                link_reg   <= 1'b0;
                o_id_reg   <= 16'(newid_reg);
                o_st_reg   <= full_reg ? ST_FULL : (newid_reg != '0 ? ST_OK : ST_MISS);
            end
            S_FND_WT: begin
                o_id_reg   <= 16'(cur_reg);
                o_mpos_reg <= pos_q;
                o_opp_reg  <= opp_q;
                o_st_reg   <= ST_OK;
            end
            default: ;
        endcase
    end

    // the pool never grows past its limit
    a_pool: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= POOL_LIMIT) else $error("pool overflow");
    // no new request while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("ready while result pending");
    // a result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    // insert only on a pool with room bumps the count
    a_ins: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INSERT && !pool_ok |=> $stable(used_reg)) else $error("bad insert");

endmodule
